FILE: rtl/rv32_pkg.sv
package rv32_pkg;

  localparam int unsigned MemWords = 1024;
  localparam int unsigned MemAw = $clog2(MemWords);
  localparam logic [31:0] DataBaseReset = 32'h1000_0000;

  typedef enum logic [1:0] {
    CMD_EXEC = 2'd0,
    CMD_PRELOAD = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [6:0] OpReg = 7'd51;
  localparam logic [6:0] OpImm = 7'd19;
  localparam logic [6:0] OpLoad = 7'd3;
  localparam logic [6:0] OpStore = 7'd35;
  localparam logic [6:0] OpBranch = 7'd99;
  localparam logic [6:0] OpLui = 7'd55;
  localparam logic [6:0] OpAuipc = 7'd23;
  localparam logic [6:0] OpJal = 7'd111;
  localparam logic [6:0] OpJalr = 7'd103;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] instr_word;
    logic [31:0] mem_address;
    logic [31:0] mem_word;
    logic [4:0]  reg_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [31:0] reg_value;
    logic        mem_fault;
  } out_item_t;

endpackage

FILE: rtl/rv32_if.sv
interface rv32_in_if;
  import rv32_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rv32_out_if;
  import rv32_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rv32_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/rv32i_instruction_executor_core.sv
// RV32I executor. Each transfer on in_ carries one command: execute the
// instruction at the current pc, preload one data word, read a register, or do nothing.
// Each command yields exactly one transfer on out_ with the pc after the
// command, the register value for a read, and an address fault flag.
// The cfg_ channel writes the data base address (the byte address of word
// zero); write it only while the block is idle.
// Each item passes stage one, which reads the register file and decodes and
// issues the data memory read, then stage two, which writes registers,
// memory and pc and loads the output register. The next item may enter in
// the cycle after stage two completes, so no item is taken before the last
// is done. The dependence of each instruction on the previous one's
// register, memory and pc writes is the reason; the synchronous data memory
// read sits in between. Reset clears the registers and pc, sets the base to
// DataBaseReset, then a clearing pass writes zero to all 1024 data words,
// one word per cycle, so input is held off until it ends. When the receiver
// stalls, the result waits in the output register and the next item waits in
// stage two; input is held off while stage two is occupied.
module rv32i_instruction_executor_core
  import rv32_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  rv32_in_if.sink     in_ch,
  rv32_out_if.source  out_ch,
  rv32_cfg_if.sink    cfg_ch
);

  logic [31:0] base_r;
  logic [31:0] regs_r [32];
  logic [31:0] pc_r;
  logic [31:0] dmem [MemWords];
  logic [31:0] rd_data_r;

  // Clearing pass over the data memory after reset.
  logic             clr_busy_r;
  logic [MemAw-1:0] clr_idx_r;

  // Stage two holding register.
  logic        s2_v_r;
  logic [1:0]  s2_cmd_r;
  logic [31:0] s2_ins_r;
  logic [31:0] s2_a_r;
  logic [31:0] s2_b_r;
  logic        s2_inr_r;
  logic [MemAw-1:0] s2_idx_r;
  logic [31:0] s2_word_r;
  logic [31:0] s2_regv_r;

  logic        out_v_r;
  out_item_t   out_r;

  logic s1_go, s2_done;

  assign cfg_ch.ready = 1'b1;
  assign s2_done = s2_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s2_v_r && !clr_busy_r;
  assign s1_go = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.payload = out_r;

  // Stage one: operand read and address computation.
  logic [31:0] ins1, a1, b1, addr1, off1, immi1, imms1;
  logic [6:0]  op1;
  always_comb begin
    ins1 = in_ch.payload.instr_word;
    op1 = ins1[6:0];
    a1 = regs_r[ins1[19:15]];
    b1 = regs_r[ins1[24:20]];
    immi1 = {{20{ins1[31]}}, ins1[31:20]};
    imms1 = {{20{ins1[31]}}, ins1[31:25], ins1[11:7]};
    if (in_ch.payload.cmd == CMD_PRELOAD) begin
      addr1 = in_ch.payload.mem_address;
    end else if (op1 == OpStore) begin
      addr1 = a1 + imms1;
    end else begin
      addr1 = a1 + immi1;
    end
    off1 = addr1 - base_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_go) begin
      s2_v_r <= 1'b1;
    end else if (s2_done) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_cmd_r <= in_ch.payload.cmd;
      s2_ins_r <= ins1;
      s2_a_r <= a1;
      s2_b_r <= b1;
      s2_inr_r <= (off1 >> 2) < 32'(MemWords);
      s2_idx_r <= off1[MemAw+1:2];
      s2_word_r <= in_ch.payload.mem_word;
      s2_regv_r <= regs_r[in_ch.payload.reg_index];
      rd_data_r <= dmem[off1[MemAw+1:2]];
    end
  end

  // Stage two: execute and write back.
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] immi, immb, immj, alu_b, alu_y, ld, st, npc, wval, shv;
  logic        wen, alt, alu_ok, tk, st_en, fault;
  logic [4:0]  sh;
  always_comb begin
    op = s2_ins_r[6:0];
    rd = s2_ins_r[11:7];
    f3 = s2_ins_r[14:12];
    f7 = s2_ins_r[31:25];
    immi = {{20{s2_ins_r[31]}}, s2_ins_r[31:20]};
    immb = {{20{s2_ins_r[31]}}, s2_ins_r[7], s2_ins_r[30:25], s2_ins_r[11:8], 1'b0};
    immj = {{12{s2_ins_r[31]}}, s2_ins_r[19:12], s2_ins_r[20], s2_ins_r[30:21], 1'b0};
    alu_b = (op == OpReg) ? s2_b_r : immi;
    alt = 1'b0;
    alu_ok = 1'b1;
    if (op == OpReg) begin
      if (f7 == 7'd32 && (f3 == 3'd0 || f3 == 3'd5)) alt = 1'b1;
      else if (f7 != 7'd0) alu_ok = 1'b0;
    end else if (f3 == 3'd5) begin
      if (f7 == 7'd32) alt = 1'b1;
      else if (f7 != 7'd0) alu_ok = 1'b0;
    end
    sh = alu_b[4:0];
    shv = $signed(s2_a_r) >>> sh;
    case (f3)
      3'd0: alu_y = alt ? s2_a_r - alu_b : s2_a_r + alu_b;
      3'd1: alu_y = s2_a_r << sh;
      3'd2: alu_y = {31'd0, $signed(s2_a_r) < $signed(alu_b)};
      3'd3: alu_y = {31'd0, s2_a_r < alu_b};
      3'd4: alu_y = s2_a_r ^ alu_b;
      3'd5: alu_y = alt ? shv : s2_a_r >> sh;
      3'd6: alu_y = s2_a_r | alu_b;
      default: alu_y = s2_a_r & alu_b;
    endcase
    ld = s2_inr_r ? rd_data_r : 32'd0;
    case (f3)
      3'd0: ld = {{24{ld[7]}}, ld[7:0]};
      3'd1: ld = {{16{ld[15]}}, ld[15:0]};
      3'd4: ld = {24'd0, ld[7:0]};
      3'd5: ld = {16'd0, ld[15:0]};
      default: ;
    endcase
    case (f3)
      3'd0: tk = s2_a_r == s2_b_r;
      3'd1: tk = s2_a_r != s2_b_r;
      3'd4: tk = $signed(s2_a_r) < $signed(s2_b_r);
      3'd5: tk = $signed(s2_a_r) >= $signed(s2_b_r);
      3'd6: tk = s2_a_r < s2_b_r;
      3'd7: tk = s2_a_r >= s2_b_r;
      default: tk = 1'b0;
    endcase
    case (f3)
      3'd0: st = {24'd0, s2_b_r[7:0]};
      3'd1: st = {16'd0, s2_b_r[15:0]};
      default: st = s2_b_r;
    endcase
    npc = pc_r + 32'd4;
    wen = 1'b0;
    wval = alu_y;
    st_en = 1'b0;
    fault = 1'b0;
    if (s2_cmd_r == CMD_EXEC) begin
      unique case (op)
        OpReg, OpImm: wen = alu_ok;
        OpLoad: begin
          wen = 1'b1;
          wval = ld;
          fault = !s2_inr_r;
        end
        OpStore: begin
          if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2) begin
            st_en = s2_inr_r;
            fault = !s2_inr_r;
          end
        end
        OpBranch: if (tk) npc = pc_r + immb;
        OpLui: begin
          wen = 1'b1;
          wval = {s2_ins_r[31:12], 12'd0};
        end
        OpAuipc: begin
          wen = 1'b1;
          wval = pc_r + {s2_ins_r[31:12], 12'd0};
        end
        OpJal: begin
          wen = 1'b1;
          wval = pc_r + 32'd4;
          npc = pc_r + immj;
        end
        OpJalr: begin
          wen = 1'b1;
          wval = pc_r + 32'd4;
          npc = (s2_a_r + immi) & ~32'd1;
        end
        default: ;
      endcase
    end else begin
      npc = pc_r;
      if (s2_cmd_r == CMD_PRELOAD) begin
        st_en = s2_inr_r;
        fault = !s2_inr_r;
        st = s2_word_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 32'd0;
      base_r <= DataBaseReset;
      out_v_r <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_idx_r <= '0;
      for (int i = 0; i < 32; i++) regs_r[i] <= 32'd0;
    end else begin
      if (cfg_ch.valid) base_r <= cfg_ch.payload;
      if (out_ch.ready) out_v_r <= 1'b0;
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == MemAw'(MemWords - 1)) clr_busy_r <= 1'b0;
      end
      if (s2_done) begin
        pc_r <= npc;
        out_v_r <= 1'b1;
        if (wen && rd != 5'd0) regs_r[rd] <= wval;
      end
    end
  end

  // Output register and data memory write port; the clearing pass owns the
  // write port until it finishes.
  always_ff @(posedge clk) begin
    if (s2_done) begin
      out_r.next_pc <= npc;
      out_r.reg_value <= (s2_cmd_r == CMD_READ) ? s2_regv_r : 32'd0;
      out_r.mem_fault <= fault;
    end
    if (clr_busy_r) begin
      dmem[clr_idx_r] <= 32'd0;
    end else if (s2_done && st_en) begin
      dmem[s2_idx_r] <= st;
    end
  end

endmodule

FILE: test/rv32i_instruction_executor_core_tb.sv
`timescale 1ns / 1ps

module rv32i_instruction_executor_core_tb;
  import rv32_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rv32_in_if  in_ch ();
  rv32_out_if out_ch ();
  rv32_cfg_if cfg_ch ();

  rv32i_instruction_executor_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow architectural state of the executor.
  logic [31:0] shadow_regs [32];
  logic [31:0] shadow_pc;
  logic [31:0] shadow_words [MemWords];
  logic        shadow_valid [MemWords];
  logic [31:0] shadow_base;

  out_item_t expected_results [$];
  int        error_count = 0;
  int        cycle_count = 0;

  // Idling controls, in percent.
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;

  function automatic logic [31:0] sign_ext(logic [31:0] v, int bits);
    logic [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((m << 1) - 32'd1);
    return (v ^ m) - m;
  endfunction

  function automatic bit map_address(logic [31:0] addr, output int unsigned word_idx);
    logic [31:0] offset;
    offset = addr - shadow_base;
    word_idx = offset >> 2;
    return offset < MemWords * 4;
  endfunction

  function automatic void put_reg(logic [4:0] rd, logic [31:0] v);
    if (rd != 5'd0) shadow_regs[rd] = v;
  endfunction

  function automatic logic [31:0] alu_result(logic [2:0] f3, bit alt, logic [31:0] a,
                                             logic [31:0] b);
    case (f3)
      3'd0: return alt ? a - b : a + b;
      3'd1: return a << b[4:0];
      3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      3'd3: return (a < b) ? 32'd1 : 32'd0;
      3'd4: return a ^ b;
      3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6: return a | b;
      default: return a & b;
    endcase
  endfunction

  // Executes one instruction on the shadow state and returns the next pc.
  function automatic logic [31:0] execute_instr(logic [31:0] ins, output bit fault);
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, pc, immi, imm, d;
    int unsigned widx;
    bit          taken;
    op = ins[6:0];
    rd = ins[11:7];
    f3 = ins[14:12];
    f7 = ins[31:25];
    a = shadow_regs[ins[19:15]];
    b = shadow_regs[ins[24:20]];
    pc = shadow_pc;
    immi = sign_ext(ins >> 20, 12);
    fault = 1'b0;
    case (op)
      OpReg: begin
        if (f7 == 7'd0) put_reg(rd, alu_result(f3, 1'b0, a, b));
        else if (f7 == 7'd32 && (f3 == 3'd0 || f3 == 3'd5))
          put_reg(rd, alu_result(f3, 1'b1, a, b));
        return pc + 4;
      end
      OpImm: begin
        if (f3 == 3'd1) put_reg(rd, a << ins[24:20]);
        else if (f3 == 3'd5) begin
          if (f7 == 7'd0 || f7 == 7'd32)
            put_reg(rd, alu_result(3'd5, f7 == 7'd32, a, {27'd0, ins[24:20]}));
        end else put_reg(rd, alu_result(f3, 1'b0, a, immi));
        return pc + 4;
      end
      OpLoad: begin
        d = '0;
        if (map_address(a + immi, widx)) begin
          if (shadow_valid[widx]) d = shadow_words[widx];
        end else fault = 1'b1;
        case (f3)
          3'd0: d = sign_ext(d, 8);
          3'd1: d = sign_ext(d, 16);
          3'd4: d = d & 32'h0000_00ff;
          3'd5: d = d & 32'h0000_ffff;
          default: ;
        endcase
        put_reg(rd, d);
        return pc + 4;
      end
      OpStore: begin
        imm = sign_ext({20'd0, ins[31:25], ins[11:7]}, 12);
        case (f3)
          3'd0: d = b & 32'h0000_00ff;
          3'd1: d = b & 32'h0000_ffff;
          3'd2: d = b;
          default: return pc + 4;
        endcase
        if (map_address(a + imm, widx)) begin
          shadow_words[widx] = d;
          shadow_valid[widx] = 1'b1;
        end else fault = 1'b1;
        return pc + 4;
      end
      OpBranch: begin
        imm = sign_ext({19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
        case (f3)
          3'd0: taken = a == b;
          3'd1: taken = a != b;
          3'd4: taken = $signed(a) < $signed(b);
          3'd5: taken = !($signed(a) < $signed(b));
          3'd6: taken = a < b;
          3'd7: taken = a >= b;
          default: taken = 1'b0;
        endcase
        return taken ? pc + imm : pc + 4;
      end
      OpLui: begin
        put_reg(rd, {ins[31:12], 12'd0});
        return pc + 4;
      end
      OpAuipc: begin
        put_reg(rd, pc + {ins[31:12], 12'd0});
        return pc + 4;
      end
      OpJal: begin
        imm = sign_ext({11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
        put_reg(rd, pc + 4);
        return pc + imm;
      end
      OpJalr: begin
        imm = (a + immi) & ~32'd1;
        put_reg(rd, pc + 4);
        return imm;
      end
      default: return pc + 4;
    endcase
  endfunction

  // Applies one item to the shadow state and returns the result it causes.
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t   r;
    bit          fault;
    int unsigned widx;
    r = '0;
    fault = 1'b0;
    case (cmd_t'(it.cmd))
      CMD_EXEC: shadow_pc = execute_instr(it.instr_word, fault);
      CMD_PRELOAD: begin
        if (map_address(it.mem_address, widx)) begin
          shadow_words[widx] = it.mem_word;
          shadow_valid[widx] = 1'b1;
        end else fault = 1'b1;
      end
      CMD_READ: r.reg_value = shadow_regs[it.reg_index];
      default: ;
    endcase
    r.next_pc = shadow_pc;
    r.mem_fault = fault;
    return r;
  endfunction

  // Input driver: offers one item and waits for its transfer. Valid stays
  // high after the transfer so that items can follow back to back.
  task automatic send_item(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(predict_result(it));
  endtask

  // Writes the base address register while the block is idle.
  task automatic write_base(logic [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    shadow_base = v;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver ready pattern, with an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n || recv_hold) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // Result checker: compares each transfer with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_ch.payload);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.payload.next_pc !== want.next_pc) begin
          $display("%0t: next_pc expected %h actual %h", $time, want.next_pc,
                   out_ch.payload.next_pc);
          error_count++;
        end
        if (out_ch.payload.reg_value !== want.reg_value) begin
          $display("%0t: reg_value expected %h actual %h", $time, want.reg_value,
                   out_ch.payload.reg_value);
          error_count++;
        end
        if (out_ch.payload.mem_fault !== want.mem_fault) begin
          $display("%0t: mem_fault expected %b actual %b", $time, want.mem_fault,
                   out_ch.payload.mem_fault);
          error_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("rv32i_instruction_executor_core_tb: done, errors");
      $finish;
    end
  end

  function automatic in_item_t make_item(cmd_t c, logic [31:0] ins, logic [31:0] addr,
                                         logic [31:0] word, logic [4:0] idx);
    in_item_t it;
    it.cmd = c;
    it.instr_word = ins;
    it.mem_address = addr;
    it.mem_word = word;
    it.reg_index = idx;
    return it;
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [31:0] ins;
    logic [6:0]  ops [9];
    ins = $urandom;
    ops = '{OpReg, OpImm, OpLoad, OpStore, OpBranch, OpLui, OpAuipc, OpJal, OpJalr};
    if ($urandom_range(9) != 0) ins[6:0] = ops[$urandom_range(8)];
    // Keep rs1 mostly on a few pointer registers so that memory gets hit.
    if ((ins[6:0] == OpLoad || ins[6:0] == OpStore) && $urandom_range(3) != 0) begin
      ins[19:15] = 5'd1 + 5'($urandom_range(1));
      ins[31] = 1'b0;
    end
    if (ins[6:0] == OpReg && $urandom_range(1)) ins[31:25] = $urandom_range(1) ? 7'd32 : 7'd0;
    if (ins[6:0] == OpImm && ins[14:12] == 3'd5 && $urandom_range(1))
      ins[31:25] = $urandom_range(1) ? 7'd32 : 7'd0;
    return ins;
  endfunction

  // Random phase: a mix of execute, preload, read and idle commands.
  task automatic random_phase(int count);
    in_item_t it;
    int       pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      it = make_item(CMD_EXEC, rand_instr(), $urandom, $urandom, 5'($urandom));
      if (pick < 12) begin
        it.cmd = CMD_PRELOAD;
        if ($urandom_range(3) != 0) it.mem_address = shadow_base + $urandom_range(MemWords * 4 - 1);
      end else if (pick < 24) it.cmd = CMD_READ;
      else if (pick < 27) it.cmd = CMD_NONE;
      // Point x1 and x2 into memory every so often.
      else if (pick < 32)
        it.instr_word = {20'(shadow_base[31:12] + 32'($urandom_range(1))), 5'd1 +
                         5'($urandom_range(1)), OpLui};
      send_item(it);
    end
  endtask

  typedef struct {
    in_item_t  item;
    bit        known;
    out_item_t result;
  } stim_row_t;

  stim_row_t directed_rows [$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    out_ch.ready = 1'b0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    shadow_pc = '0;
    shadow_base = DataBaseReset;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; rows marked known carry the hand-computed result.
    directed_rows = '{
      '{make_item(CMD_READ, 0, 0, 0, 5'd31), 1, '{32'd0, 32'd0, 1'b0}},
      '{make_item(CMD_NONE, 0, 0, 0, 0), 1, '{32'd0, 32'd0, 1'b0}},
      '{make_item(CMD_PRELOAD, 0, 32'h1000_0000, 32'hffff_ffff, 0), 1,
        '{32'd0, 32'd0, 1'b0}},
      '{make_item(CMD_PRELOAD, 0, 32'h1000_1000, 32'h1, 0), 1, '{32'd0, 32'd0, 1'b1}},
      '{make_item(CMD_PRELOAD, 0, 32'h1000_0fff, 32'h8000_0081, 0), 1,
        '{32'd0, 32'd0, 1'b0}},
      '{make_item(CMD_EXEC, {20'h10000, 5'd1, OpLui}, 0, 0, 0), 1, '{32'd4, 32'd0, 1'b0}},
      '{make_item(CMD_EXEC, {12'd0, 5'd1, 3'd0, 5'd2, OpLoad}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, {12'd0, 5'd1, 3'd4, 5'd3, OpLoad}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, {12'd4092, 5'd1, 3'd1, 5'd4, OpLoad}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, {12'd4, 5'd1, 3'd2, 5'd5, OpLoad}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, {12'hfff, 5'd1, 3'd5, 5'd6, OpLoad}, 0, 0, 0), 1,
        '{32'd24, 32'd0, 1'b1}},
      '{make_item(CMD_EXEC, {7'd0, 5'd2, 5'd1, 3'd0, 5'd8, OpStore}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, {7'd0, 5'd2, 5'd1, 3'd1, 5'd12, OpStore}, 0, 0, 0), 0,
        '{0, 0, 0}},
      '{make_item(CMD_EXEC, {7'd0, 5'd2, 5'd1, 3'd3, 5'd12, OpStore}, 0, 0, 0), 0,
        '{0, 0, 0}},
      '{make_item(CMD_EXEC, {7'h7f, 5'd2, 5'd0, 3'd2, 5'd0, OpStore}, 0, 0, 0), 0,
        '{0, 0, 0}},
      '{make_item(CMD_EXEC, {7'd32, 5'd7, 5'd2, 3'd5, 5'd9, OpReg}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, {7'd32, 5'd31, 5'd2, 3'd5, 5'd10, OpImm}, 0, 0, 0), 0,
        '{0, 0, 0}},
      '{make_item(CMD_EXEC, {7'd1, 5'd3, 5'd2, 3'd0, 5'd11, OpReg}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, {12'h7ff, 5'd0, 3'd0, 5'd0, OpImm}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, {7'd0, 5'd2, 5'd2, 3'd0, 5'd8, OpBranch}, 0, 0, 0), 0,
        '{0, 0, 0}},
      '{make_item(CMD_EXEC, {7'h7f, 5'd2, 5'd2, 3'd2, 5'd31, OpBranch}, 0, 0, 0), 0,
        '{0, 0, 0}},
      '{make_item(CMD_EXEC, {20'hfffff, 5'd12, OpAuipc}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, {20'h80000, 5'd1, OpJal}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, {12'd5, 5'd1, 3'd0, 5'd1, OpJalr}, 0, 0, 0), 0, '{0, 0, 0}},
      '{make_item(CMD_EXEC, 32'hffff_ffff, 0, 0, 0), 0, '{0, 0, 0}}
    };
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item);
      if (directed_rows[i].known && expected_results[$] != directed_rows[i].result) begin
        $display("%0t: row %0d expected %h actual %h", $time, i, directed_rows[i].result,
                 expected_results[$]);
        error_count++;
      end
    end
    drain();

    // Random phases across base address settings and idling patterns.
    send_idle_pct = 11;
    recv_idle_pct = 83;
    random_phase(170);
    drain();
    write_base(32'h0000_0000);
    send_idle_pct = 83;
    recv_idle_pct = 11;
    random_phase(170);
    drain();
    write_base(32'hffff_fff0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      random_phase(170);
      begin
        recv_hold = 1'b1;
        repeat (60) @(posedge clk);
        recv_hold = 1'b0;
      end
    join
    drain();
    write_base(32'hffff_ffff);
    random_phase(20);
    drain();

    if (error_count == 0) begin
      $display("rv32i_instruction_executor_core_tb: done, clean");
    end else begin
      $display("rv32i_instruction_executor_core_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rv32_pkg.sv
rtl/rv32_if.sv
rtl/rv32i_instruction_executor_core.sv
test/rv32i_instruction_executor_core_tb.sv
